### hw/rtl/lru_stack_page_replacement_assert.svh
// Assertion macros used by the LRU stack RTL.
`ifndef LRU_STACK_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_STACK_PAGE_REPLACEMENT_ASSERT_SVH
`ifndef SYNTHESIS
`define LRU_STK_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lru_stk assertion failed");
`define LRU_STK_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lru_stk assertion failed");
`else
`define LRU_STK_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define LRU_STK_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/lru_stk_pkg.sv
// Types and constants of the LRU stack page replacement block.
`default_nettype none
package lru_stk_pkg;

   // Sequencer states, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_SHIFT  = 4'b0100,
      ST_TOP    = 4'b1000
   } st_type;

   localparam int          CFG_W            = 7;
   localparam int          FAULT_W          = 32;
   localparam logic [6:0]  FRAMES_RESET     = 7'd50;
   localparam logic        REG_FRAMES_IN_USE = 1'b0;
   localparam logic [31:0] FAULT_MAX        = 32'hFFFF_FFFF;

endpackage
`default_nettype wire

### hw/rtl/lru_stk_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lru_stk_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

### hw/rtl/lru_stack_page_replacement.sv
// The stack RAM has a single read port: a search reads every resident slot once,
// then each entry above the hit (or above the evicted bottom) is read and written one place down.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset clears occupancy, the fault count and the output; frames_in_use returns to 50.
// The stack RAM is not cleared; slots at or above occupancy are never read.
`default_nettype none
`include "lru_stack_page_replacement_assert.svh"
module lru_stack_page_replacement #(
   parameter int MAX_FRAMES = 64,
   parameter int PAGE_BITS  = 20,
   localparam int REQ_W = ((PAGE_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((PAGE_BITS + 2 + lru_stk_pkg::FAULT_W + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // Input channel.
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,   // page_number
   // Result channel.
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic      [RSP_W-1:0] rsp_tdata,   // hit, evicted_valid, evicted_page, fault_count
   // Configuration port.
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [2:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic      [31:0]      csr_prdata,
   output logic                  csr_pready
);

   localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CW = $clog2(MAX_FRAMES + 1);
   localparam int FW = lru_stk_pkg::FAULT_W;

   lru_stk_pkg::st_type state_ff, state_in;

   logic [lru_stk_pkg::CFG_W-1:0] frames_ff, frames_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [PAGE_BITS-1:0] first_ff, first_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        pend_idx_ff, pend_idx_in;
   logic                 pend_ff, pend_in;
   logic                 found_ff, found_in;
   logic [CW-1:0]        pos_ff, pos_in;
   logic [CW-1:0]        top_ff, top_in;
   logic [CW-1:0]        occ_ff, occ_in;
   logic [FW-1:0]        faults_ff, faults_in;
   logic                 hit_ff, hit_in;
   logic                 ev_valid_ff, ev_valid_in;
   logic [PAGE_BITS-1:0] ev_page_ff, ev_page_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]     rsp_data_ff, rsp_data_in;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [PAGE_BITS-1:0] ram_wdata;
   logic [AW-1:0]        ram_raddr;
   logic [PAGE_BITS-1:0] ram_rdata;

   logic [CW-1:0] limit;
   logic [CW-1:0] prev_idx;
   logic          issue;
   logic          out_free;
   logic          cfg_write;

   // ------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      frames_in = frames_ff;
      if (cfg_write && (csr_paddr[2] == lru_stk_pkg::REG_FRAMES_IN_USE)) begin
         frames_in = csr_pwdata[lru_stk_pkg::CFG_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == lru_stk_pkg::REG_FRAMES_IN_USE) begin
         csr_prdata = 32'(frames_ff);
      end
   end

   // A limit of zero acts as one frame, and anything above the stack depth as the depth.
   always_comb begin
      if (frames_ff == '0) begin
         limit = CW'(1);
      end else if (32'(frames_ff) > 32'(MAX_FRAMES)) begin
         limit = CW'(MAX_FRAMES);
      end else begin
         limit = CW'(frames_ff);
      end
   end

   // ------------------------------------------------------------------
   // Stack memory
   // ------------------------------------------------------------------
   lru_stk_ram #(
      .WIDTH (PAGE_BITS),
      .DEPTH (MAX_FRAMES)
   ) u_stack (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   assign req_tready = (state_ff == lru_stk_pkg::ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign prev_idx   = pend_idx_ff - CW'(1);
   assign ram_raddr  = idx_ff[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      page_in      = page_ff;
      first_in     = first_ff;
      idx_in       = idx_ff;
      pend_idx_in  = pend_idx_ff;
      pend_in      = 1'b0;
      found_in     = found_ff;
      pos_in       = pos_ff;
      top_in       = top_ff;
      occ_in       = occ_ff;
      faults_in    = faults_ff;
      hit_in       = hit_ff;
      ev_valid_in  = ev_valid_ff;
      ev_page_in   = ev_page_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = prev_idx[AW-1:0];
      ram_wdata    = ram_rdata;
      issue        = 1'b0;

      unique case (state_ff)
         lru_stk_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               page_in  = req_tdata[PAGE_BITS-1:0];
               idx_in   = '0;
               found_in = 1'b0;
               pos_in   = '0;
               state_in = lru_stk_pkg::ST_SEARCH;
            end
         end

         // Read every resident slot; the compare runs in the cycle after the read.
         lru_stk_pkg::ST_SEARCH: begin
            issue = (idx_ff < occ_ff);
            if (issue) begin
               idx_in      = idx_ff + CW'(1);
               pend_in     = 1'b1;
               pend_idx_in = idx_ff;
            end
            if (pend_ff) begin
               if (ram_rdata == page_ff) begin
                  found_in = 1'b1;
                  pos_in   = pend_idx_ff;
               end
               if (pend_idx_ff == '0) begin
                  first_in = ram_rdata;
               end
            end
            if (!issue && !pend_ff) begin
               state_in = lru_stk_pkg::ST_SHIFT;
               if (found_ff) begin
                  hit_in      = 1'b1;
                  ev_valid_in = 1'b0;
                  ev_page_in  = '0;
                  idx_in      = pos_ff + CW'(1);
                  top_in      = occ_ff - CW'(1);
               end else begin
                  hit_in = 1'b0;
                  if (faults_ff != lru_stk_pkg::FAULT_MAX) begin
                     faults_in = faults_ff + FW'(1);
                  end
                  if (occ_ff >= limit) begin
                     // Evict the bottom entry; everything above moves down one slot.
                     ev_valid_in = 1'b1;
                     ev_page_in  = first_ff;
                     idx_in      = CW'(1);
                     top_in      = occ_ff - CW'(1);
                  end else begin
                     // Push: nothing moves, the page lands in the first free slot.
                     ev_valid_in = 1'b0;
                     ev_page_in  = '0;
                     top_in      = occ_ff;
                     idx_in      = occ_ff + CW'(1);
                     occ_in      = occ_ff + CW'(1);
                  end
               end
            end
         end

         // Move each entry from idx up to top one slot down.
         lru_stk_pkg::ST_SHIFT: begin
            issue = (idx_ff <= top_ff);
            if (issue) begin
               idx_in      = idx_ff + CW'(1);
               pend_in     = 1'b1;
               pend_idx_in = idx_ff;
            end
            if (pend_ff) begin
               ram_we = 1'b1;
            end
            if (!issue && !pend_ff) begin
               state_in = lru_stk_pkg::ST_TOP;
            end
         end

         // Place the page on top and hand over the result when the output is free.
         lru_stk_pkg::ST_TOP: begin
            ram_we    = 1'b1;
            ram_waddr = top_ff[AW-1:0];
            ram_wdata = page_ff;
            if (out_free) begin
               rsp_valid_in                   = 1'b1;
               rsp_data_in                    = '0;
               rsp_data_in[0]                 = hit_ff;
               rsp_data_in[1]                 = ev_valid_ff;
               rsp_data_in[2 +: PAGE_BITS]    = ev_page_ff;
               rsp_data_in[2 + PAGE_BITS +: FW] = faults_ff;
               state_in                       = lru_stk_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lru_stk_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lru_stk_pkg::ST_IDLE;
         frames_ff    <= lru_stk_pkg::FRAMES_RESET;
         occ_ff       <= '0;
         faults_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frames_ff    <= frames_in;
         occ_ff       <= occ_in;
         faults_ff    <= faults_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff     <= page_in;
      first_ff    <= first_in;
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      found_ff    <= found_in;
      pos_ff      <= pos_in;
      top_ff      <= top_in;
      hit_ff      <= hit_in;
      ev_valid_ff <= ev_valid_in;
      ev_page_ff  <= ev_page_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `LRU_STK_ASSERT_NXT(a_accept_starts_search, clock, reset, req_tvalid && req_tready, state_ff == lru_stk_pkg::ST_SEARCH)
   `LRU_STK_ASSERT_IMP(a_no_write_while_search, clock, reset, state_ff == lru_stk_pkg::ST_SEARCH || state_ff == lru_stk_pkg::ST_IDLE, !ram_we)
   `LRU_STK_ASSERT_IMP(a_evict_only_on_miss, clock, reset, rsp_valid_ff, !(rsp_data_ff[0] && rsp_data_ff[1]))
   `LRU_STK_ASSERT_IMP(a_occupancy_bound, clock, reset, state_ff == lru_stk_pkg::ST_TOP, occ_ff <= CW'(MAX_FRAMES) && top_ff < occ_ff)

endmodule
`default_nettype wire

### dv/tb.sv
// Self-checking testbench for the LRU stack page replacement block.
`timescale 1ns / 1ps
`default_nettype none
module tb;

   localparam int STACK_DEPTH = 64;
   localparam int PAGE_W      = 20;
   localparam int REQ_W       = 24;
   localparam int RSP_W       = 56;
   localparam int NUM_PHASES  = 8;

   typedef struct packed {
      logic              hit;
      logic              ev_valid;
      logic [PAGE_W-1:0] ev_page;
      logic [31:0]       faults;
   } page_result_type;

   typedef struct {
      bit                            set_cfg;
      logic [lru_stk_pkg::CFG_W-1:0] cfg;
      logic [PAGE_W-1:0]             page;
      bit                            typed;
      page_result_type               want;
   } dir_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;   // page_number
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;        // hit, evicted_valid, evicted_page, fault_count
   logic             csr_psel = 1'b0;
   logic             csr_penable = 1'b0;
   logic             csr_pwrite = 1'b0;
   logic [2:0]       csr_paddr = '0;
   logic [31:0]      csr_pwdata = '0;
   logic [31:0]      csr_prdata;
   logic             csr_pready;

   // Mirror of the block's state, advanced once per accepted item.
   logic [PAGE_W-1:0]             stack_mirror [STACK_DEPTH];
   int unsigned                   occ_mirror = 0;
   logic [31:0]                   fault_mirror = '0;
   logic [lru_stk_pkg::CFG_W-1:0] frames_mirror = lru_stk_pkg::FRAMES_RESET;

   page_result_type pending_results [$];
   int              errors = 0;
   int              send_gap_pct = 0;
   int              stall_pct = 0;
   int              hold_len = 0;

   logic [PAGE_W-1:0] pool [128];
   int                pool_size;
   logic [PAGE_W-1:0] last_page;
   logic [PAGE_W-1:0] pg;

   dir_row_type dir_rows [20] = '{
      '{0, 7'd0,   20'h00000, 1, '{1'b0, 1'b0, 20'h00000, 32'd1}},
      '{0, 7'd0,   20'hFFFFF, 1, '{1'b0, 1'b0, 20'h00000, 32'd2}},
      '{0, 7'd0,   20'h00000, 1, '{1'b1, 1'b0, 20'h00000, 32'd2}},
      '{0, 7'd0,   20'hFFFFF, 1, '{1'b1, 1'b0, 20'h00000, 32'd2}},
      '{1, 7'd2,   20'h00005, 1, '{1'b0, 1'b1, 20'h00000, 32'd3}},
      '{0, 7'd0,   20'h00000, 1, '{1'b0, 1'b1, 20'hFFFFF, 32'd4}},
      // A limit of zero behaves as one frame; the stack still holds two pages.
      '{1, 7'd0,   20'h00000, 0, '0},
      '{0, 7'd0,   20'hAAAAA, 0, '0},
      '{0, 7'd0,   20'h55555, 0, '0},
      // A limit above the stack depth is clamped to the depth.
      '{1, 7'd127, 20'h12345, 0, '0},
      '{0, 7'd0,   20'h12345, 0, '0},
      '{1, 7'd1,   20'h55555, 0, '0},
      '{0, 7'd0,   20'h00000, 0, '0},
      '{0, 7'd0,   20'h80000, 0, '0},
      '{1, 7'd64,  20'h7FFFF, 0, '0},
      '{0, 7'd0,   20'h80000, 0, '0},
      '{0, 7'd0,   20'h00001, 0, '0},
      '{0, 7'd0,   20'h0FFFF, 0, '0},
      '{0, 7'd0,   20'hFFFFE, 0, '0},
      '{0, 7'd0,   20'h00001, 0, '0}
   };

   int phase_frames [NUM_PHASES] = '{64, 3, 1, 0, 127, 8, 40, 2};
   int phase_items  [NUM_PHASES] = '{250, 150, 100, 100, 150, 150, 200, 100};

   lru_stack_page_replacement dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // Applies one reference to the mirrored stack and returns what the block must report.
   function automatic page_result_type lru_reference(input logic [PAGE_W-1:0] page);
      page_result_type r;
      int unsigned     lim;
      int unsigned     pos;
      bit              found;
      lim = (frames_mirror == 0) ? 1 :
            (frames_mirror > STACK_DEPTH) ? STACK_DEPTH : frames_mirror;
      found = 1'b0;
      pos = 0;
      r = '0;
      for (int i = 0; i < occ_mirror; i++) begin
         if (stack_mirror[i] == page) begin
            found = 1'b1;
            pos = i;
         end
      end
      if (!found) begin
         if (fault_mirror != lru_stk_pkg::FAULT_MAX) fault_mirror = fault_mirror + 1;
      end
      if (!found && occ_mirror < lim) begin
         stack_mirror[occ_mirror] = page;
         occ_mirror++;
      end else begin
         // A miss on a full stack evicts the bottom entry, same shift as a hit at slot 0.
         if (!found) begin
            r.ev_valid = 1'b1;
            r.ev_page = stack_mirror[0];
            pos = 0;
         end
         for (int i = pos + 1; i < occ_mirror; i++) stack_mirror[i-1] = stack_mirror[i];
         stack_mirror[occ_mirror-1] = page;
      end
      r.hit = found;
      r.faults = fault_mirror;
      return r;
   endfunction

   // Offers one page and returns at the edge where it is taken.
   task automatic send_page(input logic [PAGE_W-1:0] page, input bit typed,
                            input page_result_type want);
      page_result_type predicted;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_W-PAGE_W){1'b0}}, page};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = lru_reference(page);
      pending_results = {pending_results, (typed ? want : predicted)};
      last_page = page;
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Writes the frame limit, then reads it back.
   task automatic set_frames(input logic [lru_stk_pkg::CFG_W-1:0] value);
      for (int rd = 0; rd < 2; rd++) begin
         csr_psel <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite <= (rd == 0);
         csr_paddr <= 3'(4 * lru_stk_pkg::REG_FRAMES_IN_USE);
         csr_pwdata <= {{(32-lru_stk_pkg::CFG_W){1'b0}}, value};
         @(posedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
         while (!csr_pready) @(posedge clock);
         if (rd == 1 && csr_prdata[lru_stk_pkg::CFG_W-1:0] !== value) begin
            $display("%0t frames_in_use readback: expected %h actual %h",
                     $time, value, csr_prdata[lru_stk_pkg::CFG_W-1:0]);
            errors++;
         end
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      frames_mirror = value;
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_gap_pct = 0;  stall_pct = 0;  end
         1: begin send_gap_pct = 58; stall_pct = 0;  end
         2: begin send_gap_pct = 0;  stall_pct = 58; end
         default: begin send_gap_pct = 28; stall_pct = 28; end
      endcase
   endtask

   // Receiver: random stalls, plus one long hold-off.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_len) @(posedge clock);
            hold_len = 0;
         end
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      page_result_type want;
      page_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[0], rsp_tdata[1], rsp_tdata[21:2], rsp_tdata[53:22]};
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result: expected none actual %h", $time, got);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (got.hit !== want.hit) begin
               $display("%0t hit: expected %h actual %h", $time, want.hit, got.hit);
               errors++;
            end
            if (got.ev_valid !== want.ev_valid) begin
               $display("%0t evicted_valid: expected %h actual %h",
                        $time, want.ev_valid, got.ev_valid);
               errors++;
            end
            if (got.ev_page !== want.ev_page) begin
               $display("%0t evicted_page: expected %h actual %h",
                        $time, want.ev_page, got.ev_page);
               errors++;
            end
            if (got.faults !== want.faults) begin
               $display("%0t fault_count: expected %0d actual %0d",
                        $time, want.faults, got.faults);
               errors++;
            end
         end
      end
   end

   initial begin
      #(30_000_000);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int unsigned lim;
      int          r;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part, starting from the reset limit of 50 frames.
      set_idling(0);
      foreach (dir_rows[i]) begin
         if (dir_rows[i].set_cfg) begin
            req_tvalid <= 1'b0;
            wait_drained();
            set_frames(dir_rows[i].cfg);
         end
         send_page(dir_rows[i].page, dir_rows[i].typed, dir_rows[i].want);
      end

      // Random part: mostly references into a working set a bit larger than the limit.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         req_tvalid <= 1'b0;
         wait_drained();
         set_frames(lru_stk_pkg::CFG_W'(phase_frames[ph]));
         set_idling(ph % 4);
         lim = (phase_frames[ph] == 0) ? 1 :
               (phase_frames[ph] > STACK_DEPTH) ? STACK_DEPTH : phase_frames[ph];
         pool_size = lim + $urandom_range(1, lim / 2 + 2);
         for (int k = 0; k < pool_size; k++) pool[k] = PAGE_W'($urandom());
         // The block holds one item at a time, so this hold-off stalls its input.
         if (ph == 2) hold_len = 400;
         for (int n = 0; n < phase_items[ph]; n++) begin
            r = $urandom_range(0, 99);
            if (r < 75) pg = pool[$urandom_range(0, pool_size - 1)];
            else if (r < 90) pg = PAGE_W'($urandom());
            else pg = last_page;
            send_page(pg, 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (150) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t results missing: expected %0d more actual 0",
                  $time, pending_results.size());
         errors++;
      end
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
`default_nettype wire

### sim.f
+incdir+hw/rtl
hw/rtl/lru_stk_pkg.sv
hw/rtl/lru_stk_ram.sv
hw/rtl/lru_stack_page_replacement.sv
dv/tb.sv
